// ===== rtl/pidff_pkg.sv =====
// Shared types, widths, codes and helper functions for the PID controller
// with feedforward. Every other file of the block imports this package.
// Depends on nothing.
package pidff_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 21;
  localparam int MODE_W    = 2;
  localparam int LIMIT_W   = 31;
  localparam int REG_IDX_W = 3;

  // Datapath widths
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ES_W      = DATA_W + STEP_W;          // |error| * step
  localparam int DIFF_W    = DATA_W + 1;               // |error change|
  localparam int QUO_W     = DIFF_W + FRAC_BITS;       // |rate| quotient
  localparam int DIV_BITS  = 2;                        // quotient bits per cycle
  localparam int DIV_ITER  = (QUO_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W     = DIV_ITER * DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);
  localparam int INC_ACC_W = ES_W + DATA_W;
  localparam int D_ACC_W   = QUO_W + DATA_W;
  localparam int ACC_W     = (INC_ACC_W > D_ACC_W) ? INC_ACC_W : D_ACC_W;
  localparam int TERM_LOG  = 56;                       // terms limited to +-2^56
  localparam int TERM_W    = TERM_LOG + 2;             // signed term width
  localparam int MAG_W     = TERM_W - 1;               // term magnitude width
  localparam int SUM_W     = TERM_W + 2;               // four-term sum width
  localparam logic [MAG_W-1:0] TERM_MAX = MAG_W'(1) << TERM_LOG;

  // Loop mode codes
  typedef enum logic [MODE_W-1:0] {
    MODE_DISABLED = 2'd0,
    MODE_POSITION = 2'd1,
    MODE_VELOCITY = 2'd2,
    MODE_EFFORT   = 2'd3
  } loop_mode_t;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_LOOP_MODE = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_GAIN_FF   = 3'd4,
    REG_INT_LIMIT = 3'd5,
    REG_LIMIT_EN  = 3'd6
  } reg_index_t;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MUL_ES,   // |error| * step
    MUL_FF,   // |target| * |gain_ff|
    MUL_P,    // |error| * |gain_p|
    MUL_IL,   // low word of |error*step| * |gain_i|
    MUL_IH,   // high word of |error*step| * |gain_i|
    MUL_DL,   // low word of |rate| * |gain_d|
    MUL_DH    // high word of |rate| * |gain_d|
  } mul_sel_t;

  // Use of the registered product
  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_ES,
    ACC_FF,
    ACC_P,
    ACC_LOAD,
    ACC_ADD_HI,
    ACC_INC,
    ACC_D
  } acc_op_t;

  // Configuration as seen by the datapath; gains held as sign and magnitude
  typedef struct packed {
    loop_mode_t          mode;
    logic [DATA_W-1:0]   gp_mag;
    logic                gp_neg;
    logic [DATA_W-1:0]   gi_mag;
    logic                gi_neg;
    logic [DATA_W-1:0]   gd_mag;
    logic                gd_neg;
    logic [DATA_W-1:0]   gff_mag;
    logic                gff_neg;
    logic [LIMIT_W-1:0]  int_limit;
    logic                limit_en;
    logic                clear;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      capture;
    logic      load_err;
    logic      div_start;
    mul_sel_t  mul_sel;
    acc_op_t   acc_op;
    logic      integ_upd;
    logic      sum1;
    logic      sum2;
    logic      zero_res;
    logic      out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mode_on;
    logic div_done;
    logic out_free;
  } status_t;

  // Magnitude of a signed word; the most negative value maps to 2^31
  function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] x);
    logic [DATA_W-1:0] neg_x;
    neg_x = DATA_W'(-x);
    return x[DATA_W-1] ? neg_x : DATA_W'(x);
  endfunction

  // Saturate a wide signed sum to a 32-bit word
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-DATA_W:0] top;
    top = v[SUM_W-1:DATA_W-1];
    if (top == '0 || top == '1) begin
      return v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // Limit a shifted product magnitude to the term limit
  function automatic logic [MAG_W-1:0] sat_mag(input logic [ACC_W-1:0] q);
    if (q > ACC_W'(TERM_MAX)) begin
      return TERM_MAX;
    end else begin
      return q[MAG_W-1:0];
    end
  endfunction

  // Apply a sign to a term magnitude
  function automatic logic signed [TERM_W-1:0] signed_term(input logic [MAG_W-1:0] mag,
                                                           input logic neg);
    logic [TERM_W-1:0] ext;
    ext = {1'b0, mag};
    return neg ? -ext : ext;
  endfunction

endpackage

// ===== rtl/pidff_sample_if.sv =====
// Sample channel: valid/ready handshake carrying one measurement sample.
// Depends on pidff_pkg for the field widths.
interface pidff_sample_if;
  import pidff_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] measured;
  logic signed [DATA_W-1:0] target;
  logic [STEP_W-1:0]        time_step;

  modport source(output valid, output measured, output target, output time_step,
                 input ready);
  modport sink(input valid, input measured, input target, input time_step,
               output ready);
endinterface

// ===== rtl/pidff_result_if.sv =====
// Result channel: valid/ready handshake carrying one controller output.
// Depends on pidff_pkg for the field widths.
interface pidff_result_if;
  import pidff_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic                     active;

  modport source(output valid, output drive, output active, input ready);
  modport sink(input valid, input drive, input active, output ready);
endinterface

// ===== rtl/pidff_regs.sv =====
// Configuration register file: loop mode, gains, integral clamp.
// Depends on pidff_pkg; gains are stored as sign and magnitude.
module pidff_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_enable,
  input  logic [pidff_pkg::REG_IDX_W-1:0] reg_index,
  input  logic [pidff_pkg::DATA_W-1:0]    write_data,
  output pidff_pkg::cfg_t                 cfg
);
  import pidff_pkg::*;

  loop_mode_t          mode;
  logic [DATA_W-1:0]   gp_mag, gi_mag, gd_mag, gff_mag;
  logic                gp_neg, gi_neg, gd_neg, gff_neg;
  logic [LIMIT_W-1:0]  int_limit;
  logic                limit_en;
  logic [DATA_W-1:0]   data_mag;

  assign data_mag = abs32($signed(write_data));

  // Write one register per transaction; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_DISABLED;
      gp_mag    <= '0;
      gp_neg    <= 1'b0;
      gi_mag    <= '0;
      gi_neg    <= 1'b0;
      gd_mag    <= '0;
      gd_neg    <= 1'b0;
      gff_mag   <= '0;
      gff_neg   <= 1'b0;
      int_limit <= '0;
      limit_en  <= 1'b0;
    end else if (write_enable) begin
      case (reg_index)
        REG_LOOP_MODE: mode <= loop_mode_t'(write_data[MODE_W-1:0]);
        REG_GAIN_P: begin
          gp_mag <= data_mag;
          gp_neg <= write_data[DATA_W-1];
        end
        REG_GAIN_I: begin
          gi_mag <= data_mag;
          gi_neg <= write_data[DATA_W-1];
        end
        REG_GAIN_D: begin
          gd_mag <= data_mag;
          gd_neg <= write_data[DATA_W-1];
        end
        REG_GAIN_FF: begin
          gff_mag <= data_mag;
          gff_neg <= write_data[DATA_W-1];
        end
        REG_INT_LIMIT: int_limit <= write_data[LIMIT_W-1:0];
        REG_LIMIT_EN:  limit_en  <= write_data[0];
        default: ;
      endcase
    end
  end

  // Present configuration; a mode write also clears the loop state
  always_comb begin
    cfg.mode      = mode;
    cfg.gp_mag    = gp_mag;
    cfg.gp_neg    = gp_neg;
    cfg.gi_mag    = gi_mag;
    cfg.gi_neg    = gi_neg;
    cfg.gd_mag    = gd_mag;
    cfg.gd_neg    = gd_neg;
    cfg.gff_mag   = gff_mag;
    cfg.gff_neg   = gff_neg;
    cfg.int_limit = int_limit;
    cfg.limit_en  = limit_en;
    cfg.clear     = write_enable && (reg_index == REG_LOOP_MODE);
  end

endmodule

// ===== rtl/pidff_div.sv =====
// Unsigned restoring divider, DIV_BITS quotient bits per cycle, for the
// error change over the time step. Depends on pidff_pkg.
module pidff_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pidff_pkg::DIV_W-1:0]  dividend,
  input  logic [pidff_pkg::STEP_W-1:0] divisor,
  output logic                         busy,
  output logic [pidff_pkg::QUO_W-1:0]  quotient
);
  import pidff_pkg::*;

  logic [DIV_W-1:0]     work;       // dividend bits shift out, quotient bits in
  logic [STEP_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     work_next;
  logic [STEP_W-1:0]    rem_next;
  logic [STEP_W:0]      trial;

  // Retire DIV_BITS quotient bits
  always_comb begin
    work_next = work;
    rem_next  = rem;
    trial     = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial     = {rem_next, work_next[DIV_W-1]};
      work_next = {work_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial        = trial - {1'b0, divisor};
        work_next[0] = 1'b1;
      end
      rem_next = trial[STEP_W-1:0];
    end
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_ITER);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Hold the operands and partial results
  always_ff @(posedge clk) begin
    if (rst) begin
      work <= '0;
      rem  <= '0;
    end else if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient = work[QUO_W-1:0];

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not go busy after start");
  a_last_iter: assert property (@(posedge clk) disable iff (rst)
    (busy && !start && cnt == DIV_CNT_W'(1)) |=> !busy)
    else $error("divider ran past its last iteration");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> $stable(work))
    else $error("divider result changed while idle");

endmodule

// ===== rtl/pidff_dp.sv =====
// Datapath: sample and loop-state registers, shared 32x32 multiplier,
// term accumulation, integral update and output register.
// Depends on pidff_pkg, pidff_div and pidff_result_if.
module pidff_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  pidff_pkg::cfg_t                    cfg,
  input  pidff_pkg::cmd_t                    cmd,
  output pidff_pkg::status_t                 status,
  input  logic signed [pidff_pkg::DATA_W-1:0] measured,
  input  logic signed [pidff_pkg::DATA_W-1:0] target,
  input  logic [pidff_pkg::STEP_W-1:0]       time_step,
  pidff_result_if.source                     result
);
  import pidff_pkg::*;

  // Sample registers
  logic signed [DATA_W-1:0] samp_meas, samp_tgt;
  logic [STEP_W-1:0]        samp_step;

  // Loop state
  logic signed [DATA_W-1:0] isum, prev;
  logic                     first_pending;

  // Working registers
  logic signed [DATA_W-1:0] e_val;
  logic [DATA_W-1:0]        e_mag, tgt_mag;
  logic                     e_neg, tgt_neg, rate_neg;
  logic [PROD_W-1:0]        prod;
  logic [ES_W-1:0]          es;
  logic [ACC_W-1:0]         acc;
  logic signed [TERM_W-1:0] ff_term, p_term, inc_term, d_term;
  logic signed [SUM_W-1:0]  s1;
  logic signed [DATA_W-1:0] res_drive;
  logic                     res_active;

  // Output register
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_drive;
  logic                     out_active;

  // Divider hookup
  logic                     div_busy;
  logic [QUO_W-1:0]         quo;
  logic [DIV_W-1:0]         dividend;

  // Combinational helpers
  logic [DATA_W:0]          err_wide;
  logic signed [DATA_W-1:0] err_sat, err_cur;
  logic [DATA_W:0]          diff_wide, diff_mag;
  logic [DATA_W-1:0]        mul_a, mul_b;
  logic signed [SUM_W-1:0]  integ_wide;
  logic signed [DATA_W-1:0] integ_sat, integ_next;
  logic signed [DATA_W:0]   integ_ext, lim_pos, lim_neg;

  // Saturated error, forced to zero on the first sample
  assign err_wide = {samp_tgt[DATA_W-1], samp_tgt} - {samp_meas[DATA_W-1], samp_meas};
  always_comb begin
    if (err_wide[DATA_W] != err_wide[DATA_W-1]) begin
      err_sat = err_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      err_sat = err_wide[DATA_W-1:0];
    end
    err_cur = first_pending ? '0 : err_sat;
  end

  // Error change magnitude, scaled for the divider
  assign diff_wide = {e_val[DATA_W-1], e_val} - {prev[DATA_W-1], prev};
  assign diff_mag  = diff_wide[DATA_W] ? -diff_wide : diff_wide;
  assign dividend  = DIV_W'({diff_mag, {FRAC_BITS{1'b0}}});

  pidff_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (samp_step),
    .busy     (div_busy),
    .quotient (quo)
  );

  // Select multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MUL_ES: begin
        mul_a = e_mag;
        mul_b = DATA_W'(samp_step);
      end
      MUL_FF: begin
        mul_a = tgt_mag;
        mul_b = cfg.gff_mag;
      end
      MUL_P: begin
        mul_a = e_mag;
        mul_b = cfg.gp_mag;
      end
      MUL_IL: begin
        mul_a = es[DATA_W-1:0];
        mul_b = cfg.gi_mag;
      end
      MUL_IH: begin
        mul_a = DATA_W'(es[ES_W-1:DATA_W]);
        mul_b = cfg.gi_mag;
      end
      MUL_DL: begin
        mul_a = quo[DATA_W-1:0];
        mul_b = cfg.gd_mag;
      end
      MUL_DH: begin
        mul_a = DATA_W'(quo[QUO_W-1:DATA_W]);
        mul_b = cfg.gd_mag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Integral: add the increment, saturate, then clamp when enabled
  always_comb begin
    integ_wide = SUM_W'(isum) + SUM_W'(inc_term);
    integ_sat  = sat32(integ_wide);
    integ_ext  = {integ_sat[DATA_W-1], integ_sat};
    lim_pos    = $signed({2'b00, cfg.int_limit});
    lim_neg    = -lim_pos;
    if (cfg.limit_en && integ_ext > lim_pos) begin
      integ_next = lim_pos[DATA_W-1:0];
    end else if (cfg.limit_en && integ_ext < lim_neg) begin
      integ_next = lim_neg[DATA_W-1:0];
    end else begin
      integ_next = integ_sat;
    end
  end

  // Loop state and output handshake
  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      isum          <= '0;
      prev          <= '0;
      first_pending <= 1'b1;
    end else begin
      if (cmd.load_err) begin
        first_pending <= 1'b0;
      end
      if (cmd.div_start) begin
        prev <= e_val;
      end
      if (cmd.integ_upd) begin
        isum <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);

    if (cmd.capture) begin
      samp_meas <= measured;
      samp_tgt  <= target;
      samp_step <= (time_step == '0) ? STEP_W'(1) : time_step;
    end

    if (cmd.load_err) begin
      e_val   <= err_cur;
      e_mag   <= abs32(err_cur);
      e_neg   <= err_cur[DATA_W-1];
      tgt_mag <= abs32(samp_tgt);
      tgt_neg <= samp_tgt[DATA_W-1];
    end

    if (cmd.div_start) begin
      rate_neg <= diff_wide[DATA_W];
    end

    case (cmd.acc_op)
      ACC_ES:     es <= prod[ES_W-1:0];
      ACC_FF:     ff_term <= signed_term(MAG_W'(prod >> FRAC_BITS), tgt_neg ^ cfg.gff_neg);
      ACC_P:      p_term <= signed_term(MAG_W'(prod >> FRAC_BITS), e_neg ^ cfg.gp_neg);
      ACC_LOAD:   acc <= ACC_W'(prod);
      ACC_ADD_HI: acc <= acc + (ACC_W'(prod) << DATA_W);
      ACC_INC:    inc_term <= signed_term(sat_mag(acc >> (2 * FRAC_BITS)),
                                          e_neg ^ cfg.gi_neg);
      ACC_D:      d_term <= signed_term(sat_mag(acc >> FRAC_BITS), rate_neg ^ cfg.gd_neg);
      default: ;
    endcase

    if (cmd.sum1) begin
      s1 <= SUM_W'(ff_term) + SUM_W'(p_term) + SUM_W'(isum);
    end
    if (cmd.sum2) begin
      res_drive  <= sat32(s1 + SUM_W'(d_term));
      res_active <= 1'b1;
    end else if (cmd.zero_res) begin
      res_drive  <= '0;
      res_active <= 1'b0;
    end

    if (cmd.out_load) begin
      out_drive  <= res_drive;
      out_active <= res_active;
    end
  end

  assign result.valid  = out_valid;
  assign result.drive  = out_drive;
  assign result.active = out_active;

  assign status.mode_on  = (cfg.mode != MODE_DISABLED);
  assign status.div_done = !div_busy;
  assign status.out_free = !out_valid || result.ready;

endmodule

// ===== rtl/pidff_ctrl.sv =====
// Controller: sequences one sample through the datapath, one step a state.
// Depends on pidff_pkg for the command and status structs.
module pidff_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pidff_pkg::status_t status,
  output pidff_pkg::cmd_t    cmd
);
  import pidff_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ZERO,
    ST_LOAD,
    ST_ES,
    ST_FF,
    ST_P,
    ST_IL,
    ST_IH,
    ST_INC_ADD,
    ST_INC_SAT,
    ST_INTEG,
    ST_WAIT_DIV,
    ST_DL,
    ST_DH,
    ST_D_ADD,
    ST_D_SAT,
    ST_SUM1,
    ST_SUM2,
    ST_WRITE
  } state_t;

  state_t state;
  logic   accept;

  assign accept = in_valid && in_ready;

  // Advance state; ready is registered alongside it
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            in_ready <= 1'b0;
            state    <= status.mode_on ? ST_LOAD : ST_ZERO;
          end
        end
        ST_ZERO:     state <= ST_WRITE;
        ST_LOAD:     state <= ST_ES;
        ST_ES:       state <= ST_FF;
        ST_FF:       state <= ST_P;
        ST_P:        state <= ST_IL;
        ST_IL:       state <= ST_IH;
        ST_IH:       state <= ST_INC_ADD;
        ST_INC_ADD:  state <= ST_INC_SAT;
        ST_INC_SAT:  state <= ST_INTEG;
        ST_INTEG:    state <= ST_WAIT_DIV;
        ST_WAIT_DIV: begin
          if (status.div_done) begin
            state <= ST_DL;
          end
        end
        ST_DL:       state <= ST_DH;
        ST_DH:       state <= ST_D_ADD;
        ST_D_ADD:    state <= ST_D_SAT;
        ST_D_SAT:    state <= ST_SUM1;
        ST_SUM1:     state <= ST_SUM2;
        ST_SUM2:     state <= ST_WRITE;
        ST_WRITE: begin
          if (status.out_free) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  // Decode datapath commands from state
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_ES;
    cmd.acc_op  = ACC_NONE;
    cmd.capture = accept;
    case (state)
      ST_ZERO: cmd.zero_res = 1'b1;
      ST_LOAD: cmd.load_err = 1'b1;
      ST_ES: begin
        cmd.mul_sel   = MUL_ES;
        cmd.div_start = 1'b1;
      end
      ST_FF: begin
        cmd.mul_sel = MUL_FF;
        cmd.acc_op  = ACC_ES;
      end
      ST_P: begin
        cmd.mul_sel = MUL_P;
        cmd.acc_op  = ACC_FF;
      end
      ST_IL: begin
        cmd.mul_sel = MUL_IL;
        cmd.acc_op  = ACC_P;
      end
      ST_IH: begin
        cmd.mul_sel = MUL_IH;
        cmd.acc_op  = ACC_LOAD;
      end
      ST_INC_ADD: cmd.acc_op = ACC_ADD_HI;
      ST_INC_SAT: cmd.acc_op = ACC_INC;
      ST_INTEG:   cmd.integ_upd = 1'b1;
      ST_DL:      cmd.mul_sel = MUL_DL;
      ST_DH: begin
        cmd.mul_sel = MUL_DH;
        cmd.acc_op  = ACC_LOAD;
      end
      ST_D_ADD:   cmd.acc_op = ACC_ADD_HI;
      ST_D_SAT:   cmd.acc_op = ACC_D;
      ST_SUM1:    cmd.sum1 = 1'b1;
      ST_SUM2:    cmd.sum2 = 1'b1;
      ST_WRITE:   cmd.out_load = status.out_free;
      default: ;
    endcase
  end

  a_accept_drops_ready: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("ready stayed high after a transaction");
  a_disabled_path: assert property (@(posedge clk) disable iff (rst)
    (accept && !status.mode_on) |=> (state == ST_ZERO))
    else $error("disabled-mode sample did not take the zero path");
  a_quotient_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DL) |-> status.div_done)
    else $error("derivative multiply started before the divider finished");

endmodule

// ===== rtl/pid_controller_feedforward.sv =====
// PID controller with setpoint feedforward, Q16.16 fixed point, one result per sample.
// An enabled sample's run time is set by the radix-4 divider that forms the error change
// over the time step (25 iterations), with the shared 32x32 multiplier's steps around
// it; sample ready returns as the result enters the output register. A sample in
// disabled mode returns zero and leaves the loop state untouched. A result waiting
// in the output register does not block the next sample's computation, only its
// final load. A write to loop_mode clears the integral, the last error and arms the
// first-sample flag. Depends on pidff_pkg, the channel interfaces, pidff_regs,
// pidff_dp (with pidff_div) and pidff_ctrl.
module pid_controller_feedforward (
  input  logic                            clk,
  input  logic                            rst,
  pidff_sample_if.sink                    sample,
  pidff_result_if.source                  result,
  input  logic                            write_enable,
  input  logic [pidff_pkg::REG_IDX_W-1:0] reg_index,
  input  logic [pidff_pkg::DATA_W-1:0]    write_data
);
  import pidff_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign sample.ready = in_ready;

  pidff_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  pidff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pidff_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .measured  (sample.measured),
    .target    (sample.target),
    .time_step (sample.time_step),
    .result    (result)
  );

endmodule

// ===== tb/tb_pid_controller_feedforward.sv =====
// Self-checking testbench for pid_controller_feedforward: drives samples and register
// writes, predicts every result with an internal fixed-point PID model in a scoreboard.
// Depends on pidff_pkg, pidff_sample_if, pidff_result_if and the RTL of the block.
module tb_pid_controller_feedforward;
  timeunit 1ns;
  timeprecision 1ps;
  import pidff_pkg::*;

  localparam logic [DATA_W-1:0]    WORD_MAX       = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0]    WORD_MIN       = 32'h8000_0000;
  localparam logic [DATA_W-1:0]    ONE_Q          = 32'h0001_0000;
  localparam logic [STEP_W-1:0]    STEP_MAX       = 21'h10_0000;
  localparam logic [REG_IDX_W-1:0] REG_SPARE      = 3'd7;
  localparam int                   WATCHDOG_LIMIT = 3000;
  localparam int                   PHASES         = 12;
  localparam int                   PHASE_ITEMS    = 120;

  typedef enum {PRESS_NONE, PRESS_SENDER, PRESS_RECEIVER, PRESS_BOTH} pressure_t;

  typedef struct {
    logic signed [DATA_W-1:0] drive;
    logic                     active;
  } drive_result_t;

  // Fixed-point PID model and queue of predicted drive values
  class drive_scoreboard;
    loop_mode_t    mode;
    longint        kp, ki, kd, kff, clamp;
    bit            clamp_on;
    longint        integ, last_err;
    bit            first_flag;
    drive_result_t predicted[$];
    int            errors;

    function new();
      mode = MODE_DISABLED;
      kp = 0; ki = 0; kd = 0; kff = 0; clamp = 0; clamp_on = 0;
      errors = 0;
      clear_loop();
    endfunction

    function void clear_loop();
      integ = 0;
      last_err = 0;
      first_flag = 1;
    endfunction

    function int pending();
      return predicted.size();
    endfunction

    // Mirror a register write; unknown indexes are dropped
    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_LOOP_MODE: begin
          mode = loop_mode_t'(data[MODE_W-1:0]);
          clear_loop();
        end
        REG_GAIN_P:    kp = longint'($signed(data));
        REG_GAIN_I:    ki = longint'($signed(data));
        REG_GAIN_D:    kd = longint'($signed(data));
        REG_GAIN_FF:   kff = longint'($signed(data));
        REG_INT_LIMIT: clamp = longint'(data[LIMIT_W-1:0]);
        REG_LIMIT_EN:  clamp_on = data[0];
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // trunc(a * b / 2^n) on magnitudes, limited to +-2^56
    function longint scaled_product(longint a, longint b, int unsigned n);
      logic [63:0]  ua, ub;
      logic [127:0] full, q;
      bit           neg;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      full = {64'd0, ua} * {64'd0, ub};
      q = full >> n;
      if (q > (128'd1 << TERM_LOG)) q = 128'd1 << TERM_LOG;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // Advance the loop state by one accepted sample and queue its drive value
    function void note_sample(logic signed [DATA_W-1:0] meas, logic signed [DATA_W-1:0] tgt,
                              logic [STEP_W-1:0] step_in);
      longint        m, t, st, err, inc, rate, dterm, ffterm, pterm;
      drive_result_t r;
      if (mode == MODE_DISABLED) begin
        r.drive = '0;
        r.active = 1'b0;
        predicted.push_back(r);
        return;
      end
      m = meas;
      t = tgt;
      st = step_in;
      if (st == 0) st = 1;
      err = clip32(t - m);
      if (first_flag) begin
        err = 0;
        first_flag = 0;
      end
      inc = scaled_product(err * st, ki, 2 * FRAC_BITS);
      integ = clip32(integ + inc);
      if (clamp_on) begin
        if (integ > clamp) integ = clamp;
        else if (integ < -clamp) integ = -clamp;
      end
      rate = ((err - last_err) * (longint'(1) << FRAC_BITS)) / st;
      dterm = scaled_product(rate, kd, FRAC_BITS);
      ffterm = scaled_product(t, kff, FRAC_BITS);
      pterm = scaled_product(err, kp, FRAC_BITS);
      r.drive = DATA_W'(clip32(ffterm + pterm + integ + dterm));
      r.active = 1'b1;
      last_err = err;
      predicted.push_back(r);
    endfunction

    // Compare one result transaction with the oldest prediction
    function void check_result(logic signed [DATA_W-1:0] drive, logic active);
      drive_result_t r;
      if (predicted.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual drive %0d active %0b",
                 $time, drive, active);
        errors++;
        return;
      end
      r = predicted.pop_front();
      if (drive !== r.drive) begin
        $display("%0t: drive mismatch, expected %0d, actual %0d", $time, r.drive, drive);
        errors++;
      end
      if (active !== r.active) begin
        $display("%0t: active mismatch, expected %0b, actual %0b", $time, r.active, active);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 write_enable;
  logic [REG_IDX_W-1:0] reg_index;
  logic [DATA_W-1:0]    write_data;
  int                   send_idle_pct;
  int                   recv_stall_pct;
  int                   quiet_cycles;
  drive_scoreboard      sb;

  pidff_sample_if sample_ch();
  pidff_result_if result_ch();

  pid_controller_feedforward dut (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample_ch),
    .result       (result_ch),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: stall at random per the current pressure
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      sb.check_result(result_ch.drive, result_ch.active);
    end
  end

  // Watchdog: end the run after too many cycles without a transaction
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void set_pressure(pressure_t p);
    case (p)
      PRESS_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PRESS_SENDER:   begin send_idle_pct = 53; recv_stall_pct = 0;  end
      PRESS_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 53; end
      default:        begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
  endfunction

  // Mix of extremes, full-range words and small signed values
  function automatic logic [DATA_W-1:0] pick_word();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = WORD_MAX;
          1:       v = WORD_MIN;
          2:       v = '0;
          3:       v = '1;
          default: v = 32'd1;
        endcase
      end
      1, 2, 3: v = $urandom;
      default: begin
        v = $urandom >> $urandom_range(7, 28);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return 21'd1;
      1:       return STEP_MAX;
      2, 3, 4: return STEP_W'($urandom_range(1, 32'h10_0000));
      default: return STEP_W'($urandom_range(1, 4096));
    endcase
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= data;
    sb.write_reg(idx, data);
  endtask

  task automatic finish_writes();
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  // Present one sample, idling at random first, and hold until the transaction
  task automatic send_sample(input logic [DATA_W-1:0] meas, input logic [DATA_W-1:0] tgt,
                             input logic [STEP_W-1:0] step);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < send_idle_pct) begin
        sample_ch.valid <= 1'b0;
      end else begin
        sample_ch.valid <= 1'b1;
        sample_ch.measured <= meas;
        sample_ch.target <= tgt;
        sample_ch.time_step <= step;
        break;
      end
    end
    do @(posedge clk); while (!sample_ch.ready);
    sb.note_sample(meas, tgt, step);
  endtask

  // Drop valid and wait for every predicted result to arrive
  task automatic end_phase();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    // disabled after reset, field extremes
    send_sample(WORD_MIN, WORD_MAX, STEP_MAX);
    send_sample(WORD_MAX, WORD_MIN, 21'd1);
    end_phase();
    // unit P and FF gains, unused index ignored, first sample forces zero error
    write_reg(REG_SPARE, 32'hffff_ffff);
    write_reg(REG_GAIN_P, ONE_Q);
    write_reg(REG_GAIN_I, ONE_Q >> 1);
    write_reg(REG_GAIN_D, ONE_Q >> 2);
    write_reg(REG_GAIN_FF, ONE_Q);
    write_reg(REG_INT_LIMIT, WORD_MAX);
    write_reg(REG_LIMIT_EN, 32'd1);
    write_reg(REG_LOOP_MODE, MODE_POSITION);
    finish_writes();
    send_sample(32'h0064_0000, 32'h00c8_0000, 21'd65);
    send_sample(32'h0064_0000, 32'h0096_0000, 21'd65);
    // error saturates both ways
    send_sample(WORD_MIN, WORD_MAX, 21'd1);
    send_sample(WORD_MAX, WORD_MIN, STEP_MAX);
    send_sample('0, '0, 21'd655);
    end_phase();
    // extreme gains, zero clamp: terms hit their limit
    write_reg(REG_GAIN_P, WORD_MAX);
    write_reg(REG_GAIN_I, WORD_MIN);
    write_reg(REG_GAIN_D, WORD_MAX);
    write_reg(REG_GAIN_FF, WORD_MIN);
    write_reg(REG_INT_LIMIT, '0);
    write_reg(REG_LOOP_MODE, MODE_VELOCITY);
    finish_writes();
    send_sample('0, '0, 21'd1);
    send_sample('0, WORD_MAX, 21'd1);
    send_sample(WORD_MAX, WORD_MIN, 21'd1);
    send_sample(WORD_MIN, WORD_MIN, STEP_MAX);
    end_phase();
    // integral clamped at one, then free to saturate
    write_reg(REG_GAIN_P, '0);
    write_reg(REG_GAIN_D, '0);
    write_reg(REG_GAIN_FF, '0);
    write_reg(REG_GAIN_I, WORD_MAX);
    write_reg(REG_INT_LIMIT, ONE_Q);
    write_reg(REG_LOOP_MODE, MODE_EFFORT);
    finish_writes();
    send_sample('0, 32'h0010_0000, 21'd256);
    send_sample('0, 32'h0010_0000, 21'd256);
    send_sample(32'h0010_0000, '0, 21'd256);
    end_phase();
    write_reg(REG_LIMIT_EN, '0);
    finish_writes();
    send_sample('0, WORD_MAX, STEP_MAX);
    send_sample('0, WORD_MAX, STEP_MAX);
    send_sample(WORD_MAX, '0, STEP_MAX);
    end_phase();
    // disabled mid-run, then enabled again
    write_reg(REG_LOOP_MODE, MODE_DISABLED);
    finish_writes();
    send_sample(32'h1234_5678, 32'h8765_4321, 21'd100);
    send_sample(WORD_MAX, WORD_MAX, STEP_MAX);
    end_phase();
    write_reg(REG_LOOP_MODE, MODE_POSITION);
    finish_writes();
    send_sample(32'h0001_0000, 32'h0002_0000, 21'd1);
    send_sample(32'h0001_0000, 32'h0003_0000, 21'd2);
    end_phase();
  endtask

  task automatic configure_random();
    logic [DATA_W-1:0] lim;
    write_reg(REG_GAIN_P, pick_word());
    write_reg(REG_GAIN_I, pick_word());
    write_reg(REG_GAIN_D, pick_word());
    write_reg(REG_GAIN_FF, pick_word());
    case ($urandom_range(0, 3))
      0:       lim = '0;
      1:       lim = WORD_MAX;
      default: lim = $urandom >> $urandom_range(1, 16);
    endcase
    write_reg(REG_INT_LIMIT, lim);
    write_reg(REG_LIMIT_EN, DATA_W'($urandom_range(0, 1)));
    // leave the mode alone now and then so the state carries over
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 9) == 0) write_reg(REG_LOOP_MODE, MODE_DISABLED);
      else write_reg(REG_LOOP_MODE, DATA_W'($urandom_range(1, 3)));
    end
    finish_writes();
  endtask

  // Mostly a tracked setpoint with small error, the rest noise
  task automatic random_phase(input int count);
    logic [DATA_W-1:0] tgt;
    logic [STEP_W-1:0] step;
    int                k;
    tgt = pick_word();
    step = pick_step();
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 9) == 0) tgt = pick_word();
        if ($urandom_range(0, 19) == 0) step = pick_step();
        send_sample(tgt - ($signed($urandom) >>> $urandom_range(8, 30)), tgt, step);
      end else begin
        send_sample(pick_word(), pick_word(), pick_step());
      end
    end
  endtask

  initial begin
    int p;
    sb = new();
    sample_ch.valid = 1'b0;
    sample_ch.measured = '0;
    sample_ch.target = '0;
    sample_ch.time_step = '0;
    result_ch.ready = 1'b0;
    write_enable = 1'b0;
    reg_index = '0;
    write_data = '0;
    quiet_cycles = 0;
    set_pressure(PRESS_NONE);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    for (p = 0; p < PHASES; p++) begin
      configure_random();
      set_pressure(pressure_t'(p % 4));
      random_phase(PHASE_ITEMS);
      end_phase();
    end
    // let any stray result show up
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
